FILE: hdl/mrm_pkg.sv
// Shared types, codes and defaults for the multiway run merge block.
package mrm_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int MAX_RUNS_DEF     = 8;

    localparam int VAL_W  = 32;
    localparam int RUN_W  = 3;
    localparam int MODE_W = 2;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0] RUNS_RESET = 4'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TAKE  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] merged_value;
        logic [RUN_W-1:0]        source_run;
        logic                    found;
        logic                    last_of_merge;
    } t_res;

endpackage

FILE: hdl/mrm_if.sv
// Valid/ready channels for input items and result items.
interface mrm_item_if;
    logic                             valid;
    logic                             ready;
    logic [mrm_pkg::MODE_W-1:0]       mode;
    logic signed [mrm_pkg::VAL_W-1:0] item_value;
    logic [mrm_pkg::RUN_W-1:0]        run_index;

    modport source (output valid, mode, item_value, run_index, input ready);
    modport sink   (input valid, mode, item_value, run_index, output ready);
endinterface

interface mrm_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [mrm_pkg::VAL_W-1:0] merged_value;
    logic [mrm_pkg::RUN_W-1:0]        source_run;
    logic                             found;
    logic                             last_of_merge;

    modport source (output valid, merged_value, source_run, found, last_of_merge,
                    input ready);
    modport sink   (input valid, merged_value, source_run, found, last_of_merge,
                    output ready);
endinterface

FILE: hdl/mrm_store.sv
// Element store: one write port, one read port with registered read data.
module mrm_store #(
    parameter int DEPTH = mrm_pkg::MAX_ELEMENTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [mrm_pkg::VAL_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [mrm_pkg::VAL_W-1:0] o_rd_data
);

    logic [mrm_pkg::VAL_W-1:0] mem [DEPTH];
    logic [mrm_pkg::VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/mrm_min.sv
// Shared signed compare unit: decides whether a candidate head beats the running best.
module mrm_min (
    input  logic                            i_cand_v,
    input  logic signed [mrm_pkg::VAL_W-1:0] i_cand,
    input  logic                            i_have,
    input  logic signed [mrm_pkg::VAL_W-1:0] i_best,
    output logic                            o_take
);

    // strict less-than keeps the earlier (lower) run on a tie
    always_comb begin
        o_take = i_cand_v && (!i_have || (i_cand < i_best));
    end

endmodule

FILE: hdl/mrm_core.sv
// Run pointers, element store and the scan sequencer that finds the smallest head.
module mrm_core #(
    parameter int MAX_ELEMENTS = mrm_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_RUNS     = mrm_pkg::MAX_RUNS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mrm_item_if.sink                  item,
    input  logic [mrm_pkg::CFG_W-1:0] i_runs,
    input  logic                      i_out_free,
    output logic                      o_emit,
    output mrm_pkg::t_res             o_res
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int PW = $clog2(MAX_ELEMENTS + 1);
    localparam int RW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

    mrm_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_head [MAX_RUNS];
    logic [PW-1:0] r_end  [MAX_RUNS];
    logic [PW-1:0] r_count;
    logic [RW-1:0] r_idx;

    logic                            r_pend_v;
    logic [RW-1:0]                   r_pend_run;
    logic                            r_pend_one;
    logic                            r_have;
    logic signed [mrm_pkg::VAL_W-1:0] r_best_val;
    logic [RW-1:0]                   r_best_run;
    logic                            r_best_one;
    logic [1:0]                      r_nne;   // nonempty runs seen, saturates at 2

    logic                      accept;
    logic                      load_ok;
    logic [MAX_RUNS-1:0]       lane_sel;
    logic [MAX_RUNS-1:0]       lane_above;
    logic [MAX_RUNS-1:0]       lane_at_top;
    logic [RW-1:0]             k_last;
    logic [31:0]               runs_ext;
    logic [PW-1:0]             head_sel;
    logic [PW-1:0]             end_sel;
    logic                      sel_nonempty;
    logic                      sel_one;
    logic                      wr_en;
    logic                      rd_en;
    logic [mrm_pkg::VAL_W-1:0] rd_data;
    logic                      cmp_take;

    // scan bound: zero counts as one run, large values clamp to MAX_RUNS
    always_comb begin
        runs_ext = 32'(i_runs);
        if (runs_ext == 32'd0) begin
            k_last = '0;
        end else if (runs_ext > 32'(MAX_RUNS)) begin
            k_last = RW'(MAX_RUNS - 1);
        end else begin
            k_last = RW'(runs_ext - 32'd1);
        end
    end

    // per-lane decode of the load target
    always_comb begin
        for (int j = 0; j < MAX_RUNS; j++) begin
            lane_sel[j]    = (32'(item.run_index) == 32'(j));
            lane_above[j]  = (32'(item.run_index) <  32'(j));
            lane_at_top[j] = (r_end[j] == r_count);
        end
        load_ok = (r_count != PW'(MAX_ELEMENTS)) && (|(lane_sel & lane_at_top));
    end

    always_comb begin
        head_sel     = r_head[r_idx];
        end_sel      = r_end[r_idx];
        sel_nonempty = (head_sel < end_sel);
        sel_one      = ((head_sel + PW'(1)) == end_sel);
    end

    assign accept = item.valid && item.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mrm_pkg::S_IDLE: begin
                if (item.valid && (item.mode == mrm_pkg::MODE_TAKE)) begin
                    n_state = mrm_pkg::S_SCAN;
                end
            end
            mrm_pkg::S_SCAN: begin
                if (r_idx == k_last) begin
                    n_state = mrm_pkg::S_DRAIN;
                end
            end
            mrm_pkg::S_DRAIN: begin
                n_state = mrm_pkg::S_EMIT;
            end
            mrm_pkg::S_EMIT: begin
                if (i_out_free) begin
                    n_state = mrm_pkg::S_IDLE;
                end
            end
            default: n_state = mrm_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        item.ready = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        o_emit     = 1'b0;
        unique case (r_state)
            mrm_pkg::S_IDLE: begin
                item.ready = 1'b1;
                wr_en      = item.valid && (item.mode == mrm_pkg::MODE_LOAD) && load_ok;
            end
            mrm_pkg::S_SCAN: begin
                rd_en = sel_nonempty;
            end
            mrm_pkg::S_DRAIN: begin
                rd_en = 1'b0;
            end
            mrm_pkg::S_EMIT: begin
                o_emit = i_out_free;
            end
            default: item.ready = 1'b0;
        endcase
    end

    always_comb begin
        o_res.found         = r_have;
        o_res.merged_value  = r_have ? r_best_val : '0;
        o_res.source_run    = r_have ? mrm_pkg::RUN_W'(r_best_run) : '0;
        o_res.last_of_merge = r_have && (r_nne == 2'd1) && r_best_one;
    end

    mrm_store #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (item.item_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (head_sel[AW-1:0]),
        .o_rd_data (rd_data)
    );

    mrm_min u_min (
        .i_cand_v (r_pend_v),
        .i_cand   ($signed(rd_data)),
        .i_have   (r_have),
        .i_best   (r_best_val),
        .o_take   (cmp_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int j = 0; j < MAX_RUNS; j++) begin
                r_head[j] <= '0;
                r_end[j]  <= '0;
            end
        end else if (accept && (item.mode == mrm_pkg::MODE_CLEAR)) begin
            r_count <= '0;
            for (int j = 0; j < MAX_RUNS; j++) begin
                r_head[j] <= '0;
                r_end[j]  <= '0;
            end
        end else if (wr_en) begin
            r_count <= r_count + PW'(1);
            for (int j = 0; j < MAX_RUNS; j++) begin
                if (lane_sel[j]) begin
                    r_end[j] <= r_count + PW'(1);
                end else if (lane_above[j]) begin
                    r_head[j] <= r_count + PW'(1);
                    r_end[j]  <= r_count + PW'(1);
                end
            end
        end else if (o_emit && r_have) begin
            for (int j = 0; j < MAX_RUNS; j++) begin
                if (32'(r_best_run) == 32'(j)) begin
                    r_head[j] <= r_head[j] + PW'(1);
                end
            end
        end
    end

    // scan pipeline: issue a head read, compare it in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_pend_v <= 1'b0;
            r_have   <= 1'b0;
            r_nne    <= '0;
        end else begin
            if (accept) begin
                r_idx    <= '0;
                r_pend_v <= 1'b0;
                r_have   <= 1'b0;
                r_nne    <= '0;
            end else if ((r_state == mrm_pkg::S_SCAN) || (r_state == mrm_pkg::S_DRAIN)) begin
                r_pend_v <= (r_state == mrm_pkg::S_SCAN) && sel_nonempty;
                if (r_state == mrm_pkg::S_SCAN) begin
                    r_idx <= (r_idx == k_last) ? '0 : r_idx + RW'(1);
                end
                if (r_pend_v && (r_nne != 2'd2)) begin
                    r_nne <= r_nne + 2'd1;
                end
                if (cmp_take) begin
                    r_have <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mrm_pkg::S_SCAN) begin
            r_pend_run <= r_idx;
            r_pend_one <= sel_one;
        end
        if (cmp_take) begin
            r_best_val <= $signed(rd_data);
            r_best_run <= r_pend_run;
            r_best_one <= r_pend_one;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PW'(MAX_ELEMENTS))
        else $error("element count beyond store depth");

    for (genvar g = 0; g < MAX_RUNS; g++) begin : g_lane_chk
        a_head_le_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_head[g] <= r_end[g])
            else $error("run head passed run end");
    end

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (item.mode == mrm_pkg::MODE_TAKE)) |=> !item.ready)
        else $error("ready high right after a take was accepted");

    a_pend_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> ($past(r_state) == mrm_pkg::S_SCAN))
        else $error("pending head read without a scan cycle");

endmodule

FILE: hdl/multiway_run_merge.sv
// Merge of up to MAX_RUNS ascending runs of signed 32-bit values into one ascending stream.
//
// Channels: i_item (valid/ready) carries mode, item_value and run_index;
// o_result (valid/ready) carries merged_value, source_run, found and
// last_of_merge. i_cfg_wr_en/i_cfg_wr_data write runs_in_use (write it
// only while idle).
// A load appends item_value to run run_index (runs filled in ascending
// order), a clear empties all runs; neither gives a result, and ready
// stays high. A take scans the heads of runs 0..runs_in_use-1 (0 counts
// as one run, values above MAX_RUNS clamp to it) one run per cycle through
// a single comparator, with a registered store read in front of it; after
// the scan and a drain step the result goes to the output register once it
// is free, and ready stays low from acceptance until it has been written.
// Ties go to the lower run. An empty take returns found 0 and all zeros.
// The output register holds a result until the receiver takes it; input
// items keep flowing meanwhile, but a second take waits in its final step
// until the register is free.
// Reset (synchronous, active low) empties all runs, sets runs_in_use to 8
// and drops o_result.valid; stored values need no clearing.
module multiway_run_merge #(
    parameter int MAX_ELEMENTS = mrm_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_RUNS     = mrm_pkg::MAX_RUNS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mrm_item_if.sink                  i_item,
    mrm_res_if.source                 o_result,
    input  logic                      i_cfg_wr_en,
    input  logic [mrm_pkg::CFG_W-1:0] i_cfg_wr_data
);

    logic [mrm_pkg::CFG_W-1:0] r_runs;
    logic                      r_out_valid;
    mrm_pkg::t_res             r_out;
    logic                      out_free;
    logic                      emit;
    mrm_pkg::t_res             res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_runs <= mrm_pkg::RUNS_RESET;
        end else if (i_cfg_wr_en) begin
            r_runs <= i_cfg_wr_data;
        end
    end

    assign out_free = !r_out_valid || o_result.ready;

    mrm_core #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_RUNS     (MAX_RUNS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .item       (i_item),
        .i_runs     (r_runs),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.merged_value  = r_out.merged_value;
    assign o_result.source_run    = r_out.source_run;
    assign o_result.found         = r_out.found;
    assign o_result.last_of_merge = r_out.last_of_merge;

endmodule

FILE: tb/mrm_merge_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the run merge: tracks runs from the item stream and checks each take result.
module mrm_merge_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mrm_item_if                       i_item,
    mrm_res_if                        i_result,
    input  logic                      i_cfg_wr_en,
    input  logic [mrm_pkg::CFG_W-1:0] i_cfg_wr_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int STORE_DEPTH = mrm_pkg::MAX_ELEMENTS_DEF;
    localparam int RUN_COUNT   = mrm_pkg::MAX_RUNS_DEF;

    logic signed [mrm_pkg::VAL_W-1:0] store_vals [STORE_DEPTH];
    logic [10:0]                      head_ptr [RUN_COUNT];
    logic [10:0]                      end_ptr [RUN_COUNT];
    logic [10:0]                      elem_count;
    logic [mrm_pkg::CFG_W-1:0]        runs_cfg;
    mrm_pkg::t_res                    merges_due[$];

    function automatic int scan_width();
        if (runs_cfg == 0) return 1;
        if (runs_cfg > RUN_COUNT) return RUN_COUNT;
        return int'(runs_cfg);
    endfunction

    task automatic merge_predict(input logic [mrm_pkg::MODE_W-1:0] mode,
                                 input logic signed [mrm_pkg::VAL_W-1:0] value,
                                 input logic [mrm_pkg::RUN_W-1:0] run);
        mrm_pkg::t_res                    res;
        bit                               have;
        int                               k;
        int                               best_run;
        int                               left;
        logic signed [mrm_pkg::VAL_W-1:0] best_val;
        logic signed [mrm_pkg::VAL_W-1:0] cand;
        case (mode)
            mrm_pkg::MODE_LOAD: begin
                // appends only at the top of the store, in run order
                if (elem_count < STORE_DEPTH && end_ptr[run] == elem_count) begin
                    store_vals[elem_count] = value;
                    elem_count = elem_count + 1'b1;
                    end_ptr[run] = elem_count;
                    for (int j = int'(run) + 1; j < RUN_COUNT; j++) begin
                        head_ptr[j] = elem_count;
                        end_ptr[j]  = elem_count;
                    end
                end
            end
            mrm_pkg::MODE_TAKE: begin
                k = scan_width();
                have = 1'b0;
                best_run = 0;
                best_val = '0;
                left = 0;
                for (int r = 0; r < k; r++) begin
                    if (head_ptr[r] < end_ptr[r]) begin
                        cand = store_vals[head_ptr[r]];
                        // strict compare: lower run keeps a tie
                        if (!have || cand < best_val) begin
                            have = 1'b1;
                            best_val = cand;
                            best_run = r;
                        end
                    end
                end
                res = '0;
                if (have) begin
                    head_ptr[best_run] = head_ptr[best_run] + 1'b1;
                    for (int r = 0; r < k; r++) begin
                        if (head_ptr[r] < end_ptr[r]) left += int'(end_ptr[r] - head_ptr[r]);
                    end
                    res.merged_value  = best_val;
                    res.source_run    = best_run[mrm_pkg::RUN_W-1:0];
                    res.found         = 1'b1;
                    res.last_of_merge = (left == 0);
                end
                merges_due.push_back(res);
            end
            mrm_pkg::MODE_CLEAR: begin
                for (int r = 0; r < RUN_COUNT; r++) begin
                    head_ptr[r] = '0;
                    end_ptr[r]  = '0;
                end
                elem_count = '0;
            end
            default: ;
        endcase
    endtask

    task automatic merge_compare();
        mrm_pkg::t_res want;
        if (merges_due.size() == 0) begin
            $error("result with none due: merged_value %0d source_run %0d found %0b",
                   i_result.merged_value, i_result.source_run, i_result.found);
            o_fail_count++;
            return;
        end
        want = merges_due.pop_front();
        if (i_result.merged_value !== want.merged_value) begin
            $error("merged_value: expected %0d, got %0d", want.merged_value,
                   i_result.merged_value);
            o_fail_count++;
        end
        if (i_result.source_run !== want.source_run) begin
            $error("source_run: expected %0d, got %0d", want.source_run, i_result.source_run);
            o_fail_count++;
        end
        if (i_result.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, i_result.found);
            o_fail_count++;
        end
        if (i_result.last_of_merge !== want.last_of_merge) begin
            $error("last_of_merge: expected %0b, got %0b", want.last_of_merge,
                   i_result.last_of_merge);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < RUN_COUNT; r++) begin
                head_ptr[r] = '0;
                end_ptr[r]  = '0;
            end
            elem_count = '0;
            runs_cfg   = mrm_pkg::RUNS_RESET;
            merges_due.delete();
        end else begin
            // results first, so a stray result never pairs with a take of this edge
            if (i_result.valid && i_result.ready) merge_compare();
            if (i_item.valid && i_item.ready)
                merge_predict(i_item.mode, i_item.item_value, i_item.run_index);
            if (i_cfg_wr_en) runs_cfg = i_cfg_wr_data;
        end
        o_pending = merges_due.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, item and config stimulus, result back-pressure, verdict.
module tb;

    localparam int RUN_COUNT = mrm_pkg::MAX_RUNS_DEF;
    localparam logic signed [mrm_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [mrm_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [mrm_pkg::CFG_W-1:0] cfg_wr_data;
    int                        fail_count;
    int                        pending;
    bit                        hold_req;
    int                        burst_left;
    int                        items_sent;

    mrm_item_if item_ch ();
    mrm_res_if  res_ch ();

    multiway_run_merge uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_item        (item_ch),
        .o_result      (res_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    mrm_merge_checker scoreboard (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_item        (item_ch),
        .i_result      (res_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Called and returns at a falling edge; valid stays up between items of a burst.
    task automatic send_item(input mrm_pkg::t_mode mode,
                             input logic signed [mrm_pkg::VAL_W-1:0] value,
                             input int run);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_ch.valid      <= 1'b1;
        item_ch.mode       <= mode;
        item_ch.item_value <= value;
        item_ch.run_index  <= mrm_pkg::RUN_W'(run);
        do @(posedge clk); while (!item_ch.ready);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_noise();
        send_item(mrm_pkg::t_mode'($urandom_range(0, 3)), $urandom,
                  $urandom_range(0, RUN_COUNT - 1));
    endtask

    // Drain: every due result back, then room for a take still in flight.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_runs(input logic [mrm_pkg::CFG_W-1:0] runs);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= runs;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int pick_value(input int style);
        case (style)
            0: return int'($urandom);
            1: return int'($urandom_range(0, 6)) - 3;
            2: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return VAL_MIN + 1;
                    3: return VAL_MAX - 1;
                    4: return 0;
                    default: return -1;
                endcase
            end
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // Clear, fill a random number of runs in order, then take them all back out.
    task automatic merge_sequence();
        int n_runs;
        int n_vals;
        int style;
        int total;
        bit messy;
        int vals[$];
        send_item(mrm_pkg::MODE_CLEAR, $urandom, $urandom_range(0, RUN_COUNT - 1));
        n_runs = $urandom_range(1, RUN_COUNT);
        style  = $urandom_range(0, 3);
        messy  = ($urandom_range(0, 7) == 0);
        total  = 0;
        for (int r = 0; r < n_runs; r++) begin
            n_vals = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
            vals.delete();
            repeat (n_vals) vals.push_back(pick_value(style));
            if (!messy) vals.sort();
            foreach (vals[i]) begin
                if ($urandom_range(0, 19) == 0) send_noise();
                if ($urandom_range(0, 11) == 0)
                    send_item(mrm_pkg::MODE_TAKE, $urandom, $urandom_range(0, RUN_COUNT - 1));
                send_item(mrm_pkg::MODE_LOAD, vals[i], r);
                total++;
            end
        end
        repeat (total + $urandom_range(0, 2)) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            send_item(mrm_pkg::MODE_TAKE, $urandom, $urandom_range(0, RUN_COUNT - 1));
        end
    endtask

    // Fill the whole store (and a few past it), then take a few.
    task automatic fill_store();
        send_item(mrm_pkg::MODE_CLEAR, 0, 0);
        for (int i = 0; i < mrm_pkg::MAX_ELEMENTS_DEF + 6; i++)
            send_item(mrm_pkg::MODE_LOAD, $urandom,
                      (i * RUN_COUNT) / (mrm_pkg::MAX_ELEMENTS_DEF + 6));
        repeat (30)
            send_item(mrm_pkg::MODE_TAKE, $urandom, $urandom_range(0, RUN_COUNT - 1));
    endtask

    // Long receiver hold-off while takes keep coming, so the input backs up.
    task automatic stall_output();
        send_item(mrm_pkg::MODE_CLEAR, 0, 0);
        for (int i = 0; i < 24; i++) send_item(mrm_pkg::MODE_LOAD, i * 3 - 30, (i / 6));
        hold_req = 1'b1;
        repeat (30)
            send_item(mrm_pkg::MODE_TAKE, $urandom, $urandom_range(0, RUN_COUNT - 1));
    endtask

    initial begin : result_sink
        int style;
        int span;
        res_ch.ready = 1'b0;
        style = 0;
        span  = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                if (span == 0) begin
                    style = $urandom_range(0, 3);
                    span  = $urandom_range(10, 80);
                end
                span--;
                case (style)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= $urandom_range(0, 1);
                    2: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [mrm_pkg::CFG_W-1:0] runs_list [6];
        int                        phase;
        int                        phase_start;
        int                        random_start;
        runs_list = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd8, 4'd4};
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        item_ch.valid      = 1'b0;
        item_ch.mode       = mrm_pkg::MODE_NOP;
        item_ch.item_value = '0;
        item_ch.run_index  = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, ties, out-of-order load, no-op, empty take, clear
        send_item(mrm_pkg::MODE_LOAD, VAL_MIN, 0);
        send_item(mrm_pkg::MODE_LOAD, 5, 0);
        send_item(mrm_pkg::MODE_LOAD, VAL_MAX, 0);
        send_item(mrm_pkg::MODE_LOAD, VAL_MIN, 1);
        send_item(mrm_pkg::MODE_LOAD, 7, 1);
        send_item(mrm_pkg::MODE_LOAD, 3, 0);
        send_item(mrm_pkg::MODE_LOAD, VAL_MAX, 2);
        send_item(mrm_pkg::MODE_LOAD, 1, 7);
        send_item(mrm_pkg::MODE_NOP, $urandom, 7);
        repeat (8) send_item(mrm_pkg::MODE_TAKE, 0, 0);
        send_item(mrm_pkg::MODE_LOAD, 9, 4);
        send_item(mrm_pkg::MODE_CLEAR, -1, 7);
        send_item(mrm_pkg::MODE_TAKE, VAL_MAX, 7);
        wait_idle();

        write_runs(4'd8);
        fill_store();
        wait_idle();

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < 500) begin
            write_runs((phase < 6) ? runs_list[phase] : 4'($urandom_range(0, 15)));
            if (phase == 1) stall_output();
            phase_start = items_sent;
            while (items_sent - phase_start < 60) merge_sequence();
            wait_idle();
            phase++;
        end

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: multiway_run_merge.f
hdl/mrm_pkg.sv
hdl/mrm_if.sv
hdl/mrm_store.sv
hdl/mrm_min.sv
hdl/mrm_core.sv
hdl/multiway_run_merge.sv
tb/mrm_merge_checker.sv
tb/tb.sv
